FILE: rtl/core/capability_record_tokenizer_assert.svh
// assertion macros for the capability record tokenizer
// no dependencies; included by the modules that carry assertions
`ifndef CAPABILITY_RECORD_TOKENIZER_ASSERT_SVH
`define CAPABILITY_RECORD_TOKENIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define CRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("crt assertion failed");
// next-cycle implication, checked out of reset
`define CRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("crt assertion failed");
`else
`define CRT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/crt_pkg.sv
// shared types and constants for the capability record tokenizer
// no dependencies; imported by every module of the block
package crt_pkg;

    localparam int INT_W = 31;
    localparam logic [INT_W-1:0] INT_MAX = 31'h7FFF_FFFF;

    // character codes
    localparam logic [7:0] CH_ESC    = 8'h1b;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_EQUAL  = 8'h3d;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_LO_N   = 8'h6e;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [1:0] OCT_DIGITS_MAX = 2'd3;

    // output queue sizing
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_SKIP    = 4'd0,
        PH_COMMENT = 4'd1,
        PH_NAME    = 4'd2,
        PH_STRING  = 4'd3,
        PH_ESCAPE  = 4'd4,
        PH_OCTAL   = 4'd5,
        PH_INT     = 4'd6,
        PH_DRAIN   = 4'd7
    } t_phase;

    typedef enum logic [2:0] {
        TK_NAME_BYTE = 3'd0,
        TK_STR_BYTE  = 3'd1,
        TK_STR_DONE  = 3'd2,
        TK_INT_DONE  = 3'd3,
        TK_BOOL_DONE = 3'd4,
        TK_REC_OK    = 3'd5,
        TK_REC_ERR   = 3'd6
    } t_kind;

    // payload holds the byte in its low bits or the integer value
    typedef struct packed {
        t_kind            kind;
        logic [INT_W-1:0] payload;
    } t_token;

    typedef struct packed {
        logic   valid0;
        logic   valid1;
        t_token tok0;
        t_token tok1;
    } t_tok_pair;

    function automatic t_token make_tok(input t_kind kind, input logic [7:0] data);
        t_token tok;
        tok.kind    = kind;
        tok.payload = {{(INT_W-8){1'b0}}, data};
        return tok;
    endfunction

endpackage

FILE: rtl/core/crt_parser.sv
// input register, parse state and token generation
// depends on crt_pkg and capability_record_tokenizer_assert.svh
`include "capability_record_tokenizer_assert.svh"
module crt_parser
    import crt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_record,
    input  logic        i_space_ok,
    output t_tok_pair   o_push
);

    logic             r_in_valid;
    logic [7:0]       r_byte;
    logic             r_end;
    t_phase           r_phase, n_phase;
    logic [9:0]       r_oct, n_oct;
    logic [1:0]       r_cnt, n_cnt;
    logic [INT_W-1:0] r_int, n_int;

    logic             consume;
    logic             is_end, is_digit, is_space;
    logic [3:0]       digit;
    logic [9:0]       oct_next;
    logic [1:0]       cnt_next;
    logic             oct_emit;
    logic [INT_W+3:0] int_prod;
    logic [INT_W-1:0] int_sat;
    logic             t0v, t1v;
    t_token           t0, t1;

    // input register advances when it is empty or when the queue can take two tokens
    assign consume = r_in_valid && i_space_ok;
    assign o_ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_data_byte;
            r_end  <= i_end_of_record;
        end
    end

    // byte classification
    assign is_end   = r_end || (r_byte == CH_NUL);
    assign is_digit = (r_byte >= CH_ZERO) && (r_byte <= CH_NINE);
    assign is_space = (r_byte == CH_SPACE) || ((r_byte >= CH_TAB) && (r_byte <= CH_CR));
    assign digit    = r_byte[3:0];

    // octal and decimal accumulation
    assign oct_next = {r_oct[6:0], 3'b000} + {6'b0, digit};
    assign cnt_next = r_cnt + 2'd1;
    assign oct_emit = (cnt_next == OCT_DIGITS_MAX) || (cnt_next == 2'd0);
    assign int_prod = {3'b0, r_int, 1'b0} + {1'b0, r_int, 3'b0}
                    + {{INT_W{1'b0}}, digit};
    assign int_sat  = (int_prod > {4'b0, INT_MAX}) ? INT_MAX : int_prod[INT_W-1:0];

    // next state
    always_comb begin
        n_phase = r_phase;
        n_oct   = r_oct;
        n_cnt   = r_cnt;
        n_int   = r_int;
        unique case (r_phase)
            PH_SKIP: begin
                if (is_end || is_space) begin
                    n_phase = PH_SKIP;
                end else if (r_byte == CH_HASH) begin
                    n_phase = PH_COMMENT;
                end else if (r_byte == CH_EQUAL) begin
                    n_phase = PH_STRING;
                end else if (r_byte == CH_COMMA) begin
                    n_phase = PH_SKIP;
                end else begin
                    n_phase = PH_NAME;
                end
            end
            PH_COMMENT: begin
                if (is_end || r_byte == CH_NL) begin
                    n_phase = PH_SKIP;
                end
            end
            PH_NAME: begin
                if (is_end || r_byte == CH_COMMA) begin
                    n_phase = PH_SKIP;
                end else if (r_byte == CH_EQUAL) begin
                    n_phase = PH_STRING;
                end else if (r_byte == CH_HASH) begin
                    n_int   = '0;
                    n_phase = PH_INT;
                end
            end
            PH_STRING: begin
                if (is_end || r_byte == CH_COMMA) begin
                    n_phase = PH_SKIP;
                end else if (r_byte == CH_BSLASH) begin
                    n_phase = PH_ESCAPE;
                end
            end
            PH_ESCAPE: begin
                if (is_end) begin
                    n_phase = PH_SKIP;
                end else if (is_digit) begin
                    n_oct   = {6'b0, digit};
                    n_cnt   = 2'd1;
                    n_phase = PH_OCTAL;
                end else begin
                    n_phase = PH_STRING;
                end
            end
            PH_OCTAL: begin
                if (is_end) begin
                    n_phase = PH_SKIP;
                end else if (is_digit) begin
                    n_oct = oct_next;
                    n_cnt = cnt_next;
                    if (oct_emit) begin
                        n_phase = PH_STRING;
                    end
                end else if (r_byte == CH_BSLASH) begin
                    n_phase = PH_ESCAPE;
                end else if (r_byte == CH_COMMA) begin
                    n_phase = PH_SKIP;
                end else begin
                    n_phase = PH_STRING;
                end
            end
            PH_INT: begin
                if (is_end || r_byte == CH_COMMA) begin
                    n_phase = PH_SKIP;
                end else if (is_digit) begin
                    n_int = int_sat;
                end else begin
                    n_phase = PH_DRAIN;
                end
            end
            PH_DRAIN: begin
                if (is_end) begin
                    n_phase = PH_SKIP;
                end
            end
            default: begin
                n_phase = PH_SKIP;
            end
        endcase
    end

    // token outputs; a second token only follows pending octal digits
    always_comb begin
        t0v = 1'b0;
        t1v = 1'b0;
        t0  = make_tok(TK_NAME_BYTE, CH_NUL);
        t1  = make_tok(TK_NAME_BYTE, CH_NUL);
        unique case (r_phase)
            PH_SKIP, PH_NAME: begin
                if (is_end) begin
                    t0v = 1'b1;
                    t0  = make_tok(TK_REC_OK, CH_NUL);
                end else if (r_byte == CH_COMMA) begin
                    t0v = 1'b1;
                    t0  = make_tok(TK_BOOL_DONE, CH_NUL);
                end else if (r_byte == CH_HASH || r_byte == CH_EQUAL) begin
                    t0v = 1'b0;
                end else if (r_phase == PH_SKIP && is_space) begin
                    t0v = 1'b0;
                end else begin
                    t0v = 1'b1;
                    t0  = make_tok(TK_NAME_BYTE, r_byte);
                end
            end
            PH_COMMENT: begin
                if (is_end) begin
                    t0v = 1'b1;
                    t0  = make_tok(TK_REC_OK, CH_NUL);
                end
            end
            PH_STRING: begin
                if (is_end) begin
                    t0v = 1'b1;
                    t0  = make_tok(TK_REC_ERR, CH_NUL);
                end else if (r_byte == CH_COMMA) begin
                    t0v = 1'b1;
                    t0  = make_tok(TK_STR_DONE, CH_NUL);
                end else if (r_byte != CH_BSLASH) begin
                    t0v = 1'b1;
                    t0  = make_tok(TK_STR_BYTE, r_byte);
                end
            end
            PH_ESCAPE: begin
                if (is_end) begin
                    t0v = 1'b1;
                    t0  = make_tok(TK_REC_ERR, CH_NUL);
                end else if (r_byte == CH_UP_E || r_byte == CH_LO_E) begin
                    t0v = 1'b1;
                    t0  = make_tok(TK_STR_BYTE, CH_ESC);
                end else if (r_byte == CH_LO_R) begin
                    t0v = 1'b1;
                    t0  = make_tok(TK_STR_BYTE, CH_CR);
                end else if (r_byte == CH_LO_N) begin
                    t0v = 1'b1;
                    t0  = make_tok(TK_STR_BYTE, CH_NL);
                end else if (r_byte == CH_LO_T) begin
                    t0v = 1'b1;
                    t0  = make_tok(TK_STR_BYTE, CH_TAB);
                end else if (!is_digit) begin
                    t0v = 1'b1;
                    t0  = make_tok(TK_STR_BYTE, r_byte);
                end
            end
            PH_OCTAL: begin
                if (is_end) begin
                    t0v = 1'b1;
                    t0  = make_tok(TK_STR_BYTE, r_oct[7:0]);
                    t1v = 1'b1;
                    t1  = make_tok(TK_REC_ERR, CH_NUL);
                end else if (is_digit) begin
                    t0v = oct_emit;
                    t0  = make_tok(TK_STR_BYTE, oct_next[7:0]);
                end else begin
                    // pending byte, then a string end for a comma or the byte itself unless a backslash
                    t0v = 1'b1;
                    t0  = make_tok(TK_STR_BYTE, r_oct[7:0]);
                    if (r_byte == CH_COMMA) begin
                        t1v = 1'b1;
                        t1  = make_tok(TK_STR_DONE, CH_NUL);
                    end else if (r_byte != CH_BSLASH) begin
                        t1v = 1'b1;
                        t1  = make_tok(TK_STR_BYTE, r_byte);
                    end
                end
            end
            PH_INT: begin
                if (is_end) begin
                    t0v = 1'b1;
                    t0  = make_tok(TK_REC_ERR, CH_NUL);
                end else if (r_byte == CH_COMMA) begin
                    t0v        = 1'b1;
                    t0.kind    = TK_INT_DONE;
                    t0.payload = r_int;
                end else if (!is_digit) begin
                    t0v = 1'b1;
                    t0  = make_tok(TK_REC_ERR, CH_NUL);
                end
            end
            PH_DRAIN: begin
                t0v = 1'b0;
            end
            default: begin
                t0v = 1'b0;
            end
        endcase
    end

    assign o_push.valid0 = consume && t0v;
    assign o_push.valid1 = consume && t1v;
    assign o_push.tok0   = t0;
    assign o_push.tok1   = t1;

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_oct   <= '0;
            r_cnt   <= '0;
            r_int   <= '0;
        end else if (consume) begin
            r_phase <= n_phase;
            r_oct   <= n_oct;
            r_cnt   <= n_cnt;
            r_int   <= n_int;
        end
    end

    `CRT_ASSERT_NOW(a_pair_order, i_clk, i_rst_n, o_push.valid1, o_push.valid0)
    `CRT_ASSERT_NOW(a_pair_octal, i_clk, i_rst_n, o_push.valid1, r_phase == PH_OCTAL)
    `CRT_ASSERT_NEXT(a_end_to_skip, i_clk, i_rst_n, consume && is_end, r_phase == PH_SKIP)

endmodule

FILE: rtl/core/crt_token_fifo.sv
// output queue of tokens, up to two written and one read per cycle
// depends on crt_pkg and capability_record_tokenizer_assert.svh
`include "capability_record_tokenizer_assert.svh"
module crt_token_fifo
    import crt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_tok_pair i_push,
    output logic      o_space_ok,
    output logic      o_valid,
    input  logic      i_ready,
    output t_token    o_tok
);

    t_token             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;
    logic [FIFO_CW-1:0] push_n;
    logic               pop;

    assign push_n     = FIFO_CW'(i_push.valid0) + FIFO_CW'(i_push.valid1);
    assign pop        = o_valid && i_ready;
    assign o_valid    = (r_count != '0);
    assign o_space_ok = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign o_tok      = r_mem[r_rd_ptr];

    // token storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid0) begin
            r_mem[r_wr_ptr] <= i_push.tok0;
        end
        if (i_push.valid1) begin
            r_mem[r_wr_ptr + FIFO_AW'(1)] <= i_push.tok1;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + push_n - FIFO_CW'(pop);
        end
    end

    `CRT_ASSERT_NOW(a_fill_max, i_clk, i_rst_n, 1'b1, r_count <= FIFO_CW'(FIFO_DEPTH))
    `CRT_ASSERT_NOW(a_push_room, i_clk, i_rst_n, i_push.valid0, o_space_ok)
    `CRT_ASSERT_NEXT(a_pop_only, i_clk, i_rst_n, pop && push_n == '0,
        r_count == $past(r_count) - FIFO_CW'(1))

endmodule

FILE: rtl/core/capability_record_tokenizer.sv
// top level of the capability record tokenizer: parser and token queue
// depends on crt_pkg, crt_parser and crt_token_fifo
//
//  channel   direction  handshake          payload
//  input     in         i_valid / o_ready  i_data_byte, i_end_of_record
//  token     out        o_valid / i_ready  o_token_kind, o_out_byte, o_int_value,
//                                          o_record_last
//
// one byte is taken per clock; a byte is held in the input register and its tokens are written to the token queue
// a byte gives zero, one or two tokens; the four-entry token queue sets the rate
// when tokens outnumber bytes, and input stalls only while that queue lacks two free slots
// synchronous active-low reset returns the parser to skipping whitespace and empties the queue
module capability_record_tokenizer
    import crt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_data_byte,
    input  logic             i_end_of_record,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [2:0]       o_token_kind,
    output logic [7:0]       o_out_byte,
    output logic [INT_W-1:0] o_int_value,
    output logic             o_record_last
);

    t_tok_pair push;
    logic      space_ok;
    t_token    tok;

    // byte parser
    crt_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_end_of_record(i_end_of_record),
        .i_space_ok     (space_ok),
        .o_push         (push)
    );

    // token queue
    crt_token_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_space_ok(space_ok),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_tok     (tok)
    );

    // unpack token fields
    assign o_token_kind  = tok.kind;
    assign o_out_byte    = (tok.kind == TK_NAME_BYTE || tok.kind == TK_STR_BYTE)
                         ? tok.payload[7:0] : 8'h00;
    assign o_int_value   = (tok.kind == TK_INT_DONE) ? tok.payload : '0;
    assign o_record_last = (tok.kind == TK_REC_OK || tok.kind == TK_REC_ERR);

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for the capability record tokenizer
// depends on crt_pkg and capability_record_tokenizer; predicts tokens in-bench, takes those of known
// rows as typed in, and runs directed rows, then well-formed and broken random records under idle patterns
module testbench;
    import crt_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int RAND_PER_PHASE = 275;
    localparam int N_PHASES       = 4;
    localparam int MAX_REPORTS    = 200;
    localparam int SEND_IDLE  [N_PHASES] = '{0, 83, 0, 38};
    localparam int RECV_STALL [N_PHASES] = '{0, 0, 83, 38};

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       data;
        logic [INT_W-1:0] value;
        logic             last;
    } t_tok_rec;

    // one input transaction; known rows carry their token typed in
    typedef struct packed {
        logic [7:0] data;
        logic       eor;
        logic       known;
        t_tok_rec   tok;
    } t_rec_byte;

    logic             i_clk           = 1'b0;
    logic             i_rst_n         = 1'b0;
    logic             i_valid         = 1'b0;
    logic [7:0]       i_data_byte     = 8'h00;
    logic             i_end_of_record = 1'b0;
    logic             i_ready         = 1'b0;
    logic             o_ready;
    logic             o_valid;
    logic [2:0]       o_token_kind;
    logic [7:0]       o_out_byte;
    logic [INT_W-1:0] o_int_value;
    logic             o_record_last;

    capability_record_tokenizer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_record (i_end_of_record),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_token_kind    (o_token_kind),
        .o_out_byte      (o_out_byte),
        .o_int_value     (o_int_value),
        .o_record_last   (o_record_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predicted parser state
    t_phase           ph;
    logic [9:0]       oct_acc;
    logic [1:0]       oct_cnt;
    logic [INT_W-1:0] int_acc;
    t_tok_rec         step_toks[$];
    t_tok_rec         tok_expect_q[$];

    t_rec_byte        cur_feed;
    t_rec_byte        plan_q[$];
    t_rec_byte        dir_tab[$];
    t_tok_rec         want;
    int               send_idle  = 0;
    int               recv_stall = 0;
    int               fail_count = 0;
    int               cycle_count = 0;

    function automatic t_tok_rec token_of(t_kind k, logic [7:0] d, logic [INT_W-1:0] v);
        t_tok_rec t;
        t.kind  = k;
        t.data  = d;
        t.value = v;
        t.last  = (k == TK_REC_OK) || (k == TK_REC_ERR);
        return t;
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // plain string byte: backslash opens an escape, comma closes the value
    function automatic void string_char(logic [7:0] b);
        if (b == CH_BSLASH) begin
            ph = PH_ESCAPE;
        end else if (b == CH_COMMA) begin
            step_toks.push_back(token_of(TK_STR_DONE, 8'h00, '0));
            ph = PH_SKIP;
        end else begin
            step_toks.push_back(token_of(TK_STR_BYTE, b, '0));
        end
    endfunction

    // tokens caused by one accepted byte, left in step_toks
    function automatic void tokenize_byte(logic [7:0] b, logic eor);
        logic        fin;
        logic [34:0] wide;
        fin = eor || (b == CH_NUL);
        step_toks.delete();
        case (ph)
            PH_SKIP: begin
                if (fin) begin
                    step_toks.push_back(token_of(TK_REC_OK, 8'h00, '0));
                end else if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
                    // whitespace between entries
                end else if (b == CH_HASH) begin
                    ph = PH_COMMENT;
                end else if (b == CH_EQUAL) begin
                    ph = PH_STRING;
                end else if (b == CH_COMMA) begin
                    step_toks.push_back(token_of(TK_BOOL_DONE, 8'h00, '0));
                end else begin
                    step_toks.push_back(token_of(TK_NAME_BYTE, b, '0));
                    ph = PH_NAME;
                end
            end
            PH_COMMENT: begin
                if (fin) begin
                    step_toks.push_back(token_of(TK_REC_OK, 8'h00, '0));
                    ph = PH_SKIP;
                end else if (b == CH_NL) begin
                    ph = PH_SKIP;
                end
            end
            PH_NAME: begin
                if (fin) begin
                    step_toks.push_back(token_of(TK_REC_OK, 8'h00, '0));
                    ph = PH_SKIP;
                end else if (b == CH_EQUAL) begin
                    ph = PH_STRING;
                end else if (b == CH_HASH) begin
                    int_acc = '0;
                    ph = PH_INT;
                end else if (b == CH_COMMA) begin
                    step_toks.push_back(token_of(TK_BOOL_DONE, 8'h00, '0));
                    ph = PH_SKIP;
                end else begin
                    step_toks.push_back(token_of(TK_NAME_BYTE, b, '0));
                end
            end
            PH_STRING: begin
                if (fin) begin
                    step_toks.push_back(token_of(TK_REC_ERR, 8'h00, '0));
                    ph = PH_SKIP;
                end else begin
                    string_char(b);
                end
            end
            PH_ESCAPE: begin
                if (fin) begin
                    step_toks.push_back(token_of(TK_REC_ERR, 8'h00, '0));
                    ph = PH_SKIP;
                end else begin
                    ph = PH_STRING;
                    if (b == CH_UP_E || b == CH_LO_E) begin
                        step_toks.push_back(token_of(TK_STR_BYTE, CH_ESC, '0));
                    end else if (b == CH_LO_R) begin
                        step_toks.push_back(token_of(TK_STR_BYTE, CH_CR, '0));
                    end else if (b == CH_LO_N) begin
                        step_toks.push_back(token_of(TK_STR_BYTE, CH_NL, '0));
                    end else if (b == CH_LO_T) begin
                        step_toks.push_back(token_of(TK_STR_BYTE, CH_TAB, '0));
                    end else if (is_digit(b)) begin
                        oct_acc = 10'(b - CH_ZERO);
                        oct_cnt = 2'd1;
                        ph = PH_OCTAL;
                    end else begin
                        step_toks.push_back(token_of(TK_STR_BYTE, b, '0));
                    end
                end
            end
            PH_OCTAL: begin
                if (fin) begin
                    step_toks.push_back(token_of(TK_STR_BYTE, oct_acc[7:0], '0));
                    step_toks.push_back(token_of(TK_REC_ERR, 8'h00, '0));
                    ph = PH_SKIP;
                end else if (is_digit(b)) begin
                    oct_acc = (oct_acc * 10'd8) + 10'(b - CH_ZERO);
                    oct_cnt = oct_cnt + 2'd1;
                    if (oct_cnt == OCT_DIGITS_MAX || oct_cnt == 2'd0) begin
                        step_toks.push_back(token_of(TK_STR_BYTE, oct_acc[7:0], '0));
                        ph = PH_STRING;
                    end
                end else begin
                    // short octal run: flush, then treat the byte as plain string
                    step_toks.push_back(token_of(TK_STR_BYTE, oct_acc[7:0], '0));
                    ph = PH_STRING;
                    string_char(b);
                end
            end
            PH_INT: begin
                if (fin) begin
                    step_toks.push_back(token_of(TK_REC_ERR, 8'h00, '0));
                    ph = PH_SKIP;
                end else if (is_digit(b)) begin
                    wide = int_acc * 35'd10 + 35'(b - CH_ZERO);
                    int_acc = (wide > 35'(INT_MAX)) ? INT_MAX : wide[INT_W-1:0];
                end else if (b == CH_COMMA) begin
                    step_toks.push_back(token_of(TK_INT_DONE, 8'h00, int_acc));
                    ph = PH_SKIP;
                end else begin
                    step_toks.push_back(token_of(TK_REC_ERR, 8'h00, '0));
                    ph = PH_DRAIN;
                end
            end
            PH_DRAIN: begin
                if (fin) begin
                    ph = PH_SKIP;
                end
            end
            default: begin
                ph = PH_SKIP;
            end
        endcase
    endfunction

    function automatic t_rec_byte row(logic [7:0] d, logic e);
        t_rec_byte r;
        r      = '0;
        r.data = d;
        r.eor  = e;
        return r;
    endfunction

    function automatic t_rec_byte row_known(logic [7:0] d, logic e, t_kind k,
                                            logic [7:0] o, logic [INT_W-1:0] v);
        t_rec_byte r;
        r       = row(d, e);
        r.known = 1'b1;
        r.tok   = token_of(k, o, v);
        return r;
    endfunction

    function automatic void note_mismatch(string field, logic [31:0] exp_v, logic [31:0] got_v);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, got_v);
    endfunction

    // record generation
    function automatic void plan(logic [7:0] d, logic e);
        plan_q.push_back(row(d, e));
    endfunction

    function automatic void plan_end();
        if ($urandom_range(0, 1) == 0)
            plan(8'($urandom_range(0, 255)), 1'b1);
        else
            plan(CH_NUL, 1'b0);
    endfunction

    function automatic void plan_name(int min_len);
        int n;
        n = $urandom_range(min_len, 4);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) == 0)
                plan(8'($urandom_range(128, 255)), 1'b0);
            else
                plan(8'($urandom_range(97, 122)), 1'b0);
        end
    endfunction

    function automatic void plan_string_body();
        int         n;
        logic [7:0] b;
        n = $urandom_range(0, 6);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 4))
                0, 1: begin
                    b = 8'($urandom_range(1, 255));
                    if (b == CH_COMMA || b == CH_BSLASH)
                        b = 8'h41;
                    plan(b, 1'b0);
                end
                2: begin
                    plan(CH_BSLASH, 1'b0);
                    case ($urandom_range(0, 5))
                        0: plan(CH_UP_E, 1'b0);
                        1: plan(CH_LO_E, 1'b0);
                        2: plan(CH_LO_R, 1'b0);
                        3: plan(CH_LO_N, 1'b0);
                        4: plan(CH_LO_T, 1'b0);
                        default: plan(CH_BSLASH, 1'b0);
                    endcase
                end
                3: begin
                    plan(CH_BSLASH, 1'b0);
                    repeat ($urandom_range(1, 3))
                        plan(8'($urandom_range(CH_ZERO, CH_NINE)), 1'b0);
                end
                default: begin
                    // any escaped byte, comma included; bytes other than digits and e, E, r, n, t pass through
                    plan(CH_BSLASH, 1'b0);
                    plan(8'($urandom_range(1, 255)), 1'b0);
                end
            endcase
        end
    endfunction

    function automatic void plan_record();
        int         n_ent;
        bit         broken;
        logic [7:0] b;
        // pure noise record
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 20))
                plan(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            plan_end();
            return;
        end
        n_ent = $urandom_range(0, 5);
        for (int k = 0; k < n_ent; k++) begin
            repeat ($urandom_range(0, 2)) begin
                b = 8'($urandom_range(8, 13));
                plan((b == 8'd8) ? CH_SPACE : b, 1'b0);
            end
            broken = ($urandom_range(0, 11) == 0);
            case ($urandom_range(0, 9))
                0: begin
                    plan(CH_HASH, 1'b0);
                    repeat ($urandom_range(0, 6)) begin
                        b = 8'($urandom_range(1, 255));
                        plan((b == CH_NL) ? 8'h2e : b, 1'b0);
                    end
                    if (broken) begin
                        plan_end();
                        return;
                    end
                    plan(CH_NL, 1'b0);
                end
                1, 2, 3: begin
                    plan_name(0);
                    if (broken) begin
                        plan_end();
                        return;
                    end
                    plan(CH_COMMA, 1'b0);
                end
                4, 5, 6: begin
                    plan_name(1);
                    plan(CH_HASH, 1'b0);
                    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(10, 14)
                                                        : $urandom_range(1, 5))
                        plan(8'($urandom_range(CH_ZERO, CH_NINE)), 1'b0);
                    if (broken) begin
                        // optionally a stray byte after the digits, then the rest is ignored
                        if ($urandom_range(0, 1) == 0) begin
                            plan(8'($urandom_range(CH_NINE + 1, 255)), 1'b0);
                            repeat ($urandom_range(0, 4))
                                plan(8'($urandom_range(1, 255)), 1'b0);
                        end
                        plan_end();
                        return;
                    end
                    plan(CH_COMMA, 1'b0);
                end
                default: begin
                    plan_name(0);
                    plan(CH_EQUAL, 1'b0);
                    plan_string_body();
                    if (broken) begin
                        if ($urandom_range(0, 1) == 0)
                            plan(CH_BSLASH, 1'b0);
                        plan_end();
                        return;
                    end
                    plan(CH_COMMA, 1'b0);
                end
            endcase
        end
        plan_end();
    endfunction

    // drive one input transaction, with random idle cycles first
    task automatic feed_byte(input t_rec_byte r);
        while ($urandom_range(0, 99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_data_byte     <= r.data;
        i_end_of_record <= r.eor;
        cur_feed         = r;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    // prediction on accepted bytes, checking of accepted tokens
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                tokenize_byte(i_data_byte, i_end_of_record);
                if (cur_feed.known)
                    tok_expect_q.push_back(cur_feed.tok);
                else
                    foreach (step_toks[k]) tok_expect_q.push_back(step_toks[k]);
            end
            if (o_valid && i_ready) begin
                if (tok_expect_q.size() == 0) begin
                    note_mismatch("unexpected token kind", 32'hFFFF_FFFF,
                                  32'(o_token_kind));
                end else begin
                    want = tok_expect_q.pop_front();
                    if (o_token_kind !== want.kind)
                        note_mismatch("token_kind", 32'(want.kind), 32'(o_token_kind));
                    if (o_out_byte !== want.data)
                        note_mismatch("out_byte", 32'(want.data), 32'(o_out_byte));
                    if (o_int_value !== want.value)
                        note_mismatch("int_value", 32'(want.value), 32'(o_int_value));
                    if (o_record_last !== want.last)
                        note_mismatch("record_last", 32'(want.last), 32'(o_record_last));
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int sent;
        ph      = PH_SKIP;
        oct_acc = '0;
        oct_cnt = '0;
        int_acc = '0;
        cur_feed = '0;

        // directed rows: extremes, every token kind, end-of-record corner cases
        dir_tab = '{
            row_known(8'hFF, 1'b1, TK_REC_OK, 8'h00, '0),       // end between entries
            row(CH_HASH, 1'b0),
            row(8'hFF, 1'b0),
            row_known(CH_NUL, 1'b0, TK_REC_OK, 8'h00, '0),      // nul inside comment
            row_known(8'h78, 1'b0, TK_NAME_BYTE, 8'h78, '0),
            row(CH_HASH, 1'b0),
            row(CH_NINE, 1'b0),
            row_known(CH_COMMA, 1'b0, TK_INT_DONE, 8'h00, 31'd9),
            row_known(CH_COMMA, 1'b0, TK_BOOL_DONE, 8'h00, '0), // empty name boolean
            row(CH_EQUAL, 1'b0),                                // empty name string
            row(CH_BSLASH, 1'b0),
            row_known(CH_UP_E, 1'b0, TK_STR_BYTE, CH_ESC, '0),
            row(CH_BSLASH, 1'b0),
            row(CH_NINE, 1'b0),
            row(CH_NINE, 1'b0),
            row(CH_NINE, 1'b0),                                 // third digit emits
            row(CH_BSLASH, 1'b0),
            row(8'h37, 1'b0),
            row(CH_COMMA, 1'b0),                                // flush plus string done
            row(CH_EQUAL, 1'b0),
            row(CH_BSLASH, 1'b0),
            row_known(8'h00, 1'b1, TK_REC_ERR, 8'h00, '0),      // backslash at end
            row(8'h6e, 1'b0),
            row(CH_HASH, 1'b0),
            row_known(8'h7a, 1'b0, TK_REC_ERR, 8'h00, '0),      // bad integer terminator
            row(8'h71, 1'b0),
            row(8'hFF, 1'b1),                                   // drained end, no token
            row(8'h61, 1'b0),
            row_known(CH_NUL, 1'b1, TK_REC_OK, 8'h00, '0)       // end inside name
        };

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[k]) feed_byte(dir_tab[k]);

        // random records under each idle pattern
        for (int p = 0; p < N_PHASES; p++) begin
            send_idle  = SEND_IDLE[p];
            recv_stall = RECV_STALL[p];
            sent = 0;
            while (sent < RAND_PER_PHASE) begin
                plan_record();
                while (plan_q.size() != 0) begin
                    feed_byte(plan_q.pop_front());
                    sent++;
                end
            end
        end
        i_valid <= 1'b0;

        while (tok_expect_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/crt_pkg.sv
rtl/core/crt_parser.sv
rtl/core/crt_token_fifo.sv
rtl/core/capability_record_tokenizer.sv
tb/sv/testbench.sv
